// ===== sv/bcdrtc_pkg.sv =====
package bcdrtc_pkg;

  // Depth of the user RAM behind the data port.
  localparam int unsigned RAM_DEPTH = 256;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_COLD  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [4:0] reg_address;
    logic [7:0] write_data;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_flag;
    logic       watchdog_reset;
  } out_t;

  // Byte register map.
  localparam logic [4:0] REG_SEC      = 5'h00;
  localparam logic [4:0] REG_CENTURY  = 5'h07;
  localparam logic [4:0] REG_ALARM0   = 5'h08;
  localparam logic [4:0] REG_ALARM3   = 5'h0B;
  localparam logic [4:0] REG_WDOG0    = 5'h0C;
  localparam logic [4:0] REG_WDOG1    = 5'h0D;
  localparam logic [4:0] REG_CTRL_A   = 5'h0E;
  localparam logic [4:0] REG_CTRL_B   = 5'h0F;
  localparam logic [4:0] REG_RAM_PTR  = 5'h10;
  localparam logic [4:0] REG_RAM_DATA = 5'h13;
  localparam logic [2:0] TIME_DOW     = 3'd3;
  localparam logic [2:0] TIME_MONTH   = 3'd5;

  // Configuration register indexes on the APB port.
  localparam logic [1:0] CFG_CPS   = 2'd0;
  localparam logic [1:0] CFG_XFER  = 2'd1;
  localparam logic [1:0] CFG_CPCS  = 2'd2;

  localparam logic [26:0] CPS_RESET  = 27'd1000000;
  localparam logic [15:0] XFER_RESET = 16'd366;
  localparam logic [19:0] CPCS_RESET = 20'd10000;

  localparam logic [7:0] MONTH_CTRL_RESET = 8'h80;
  localparam logic [13:0] WDOG_MAX = 14'h3FFF;

  // Power-up time: 2000-01-01 00:00:00, Saturday.
  localparam logic [7:0] START_TIME [8] = '{8'h00, 8'h00, 8'h00, 8'h07,
                                            8'h01, 8'h01, 8'h00, 8'h20};

endpackage

// ===== sv/bcdrtc_ram.sv =====
module bcdrtc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bcd_rtc_with_alarm_watchdog.sv =====
// Byte-register real-time clock with BCD calendar, alarm and watchdog. Every
// input transaction is a register read, a register write, one clock tick or a
// cold start, and each one yields exactly one result transaction carrying the
// read byte, the IRQF level and a watchdog-reset pulse. A transaction is
// captured in an input register and fully processed by the logic between that
// register and the result register, so the block takes one transaction per
// clock while results are taken; the input side keeps accepting while a
// finished result waits, and only stalls when both the input and the result
// register are full. The 256-byte user RAM is a registered-read memory whose
// read port always looks at the current RAM pointer, so the byte for a
// data-port read is already registered; per-entry valid flops make RAM read as
// zero after reset or cold start, with no clearing pass. The three prescale
// values are set over the APB port and should be written only while no
// transaction is in flight.
module bcd_rtc_with_alarm_watchdog
  import bcdrtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [26:0] cycles_per_second;
  logic [15:0] transfer_delay_cycles;
  logic [19:0] cycles_per_centisecond;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_second      <= CPS_RESET;
      transfer_delay_cycles  <= XFER_RESET;
      cycles_per_centisecond <= CPCS_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        CFG_CPS:  cycles_per_second      <= pwdata[26:0];
        CFG_XFER: transfer_delay_cycles  <= pwdata[15:0];
        CFG_CPCS: cycles_per_centisecond <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      CFG_CPS:  prdata = {5'd0, cycles_per_second};
      CFG_XFER: prdata = {16'd0, transfer_delay_cycles};
      CFG_CPCS: prdata = {12'd0, cycles_per_centisecond};
      default:  prdata = '0;
    endcase
  end

  // Input register and flow control.
  in_t  in_q;
  logic in_q_valid;
  logic fire;

  assign fire     = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  // Clock state.
  logic [7:0]  user_time [8];
  logic [7:0]  internal_time [8];
  logic [7:0]  month_control;
  logic [7:0]  alarm_regs [4];
  logic [7:0]  watchdog_regs [2];
  logic [13:0] watchdog_centis;
  logic [19:0] watchdog_prescale;
  logic [7:0]  control_a;
  logic [7:0]  control_b;
  logic [7:0]  ram_pointer;
  logic [26:0] second_prescale;
  logic [31:0] transfer_count;
  logic        sync_pending;
  logic        sync_needed;
  logic        last_te;
  logic [RAM_DEPTH-1:0] ram_valid;

  logic [7:0]  user_time_next [8];
  logic [7:0]  internal_time_next [8];
  logic [7:0]  month_control_next;
  logic [7:0]  alarm_regs_next [4];
  logic [7:0]  watchdog_regs_next [2];
  logic [13:0] watchdog_centis_next;
  logic [19:0] watchdog_prescale_next;
  logic [7:0]  control_a_next;
  logic [7:0]  control_b_next;
  logic [7:0]  ram_pointer_next;
  logic [26:0] second_prescale_next;
  logic [31:0] transfer_count_next;
  logic        sync_pending_next;
  logic        sync_needed_next;
  logic        last_te_next;
  logic [RAM_DEPTH-1:0] ram_valid_next;
  out_t        result_next;

  // RAM read side: the registered read always follows the pointer, and a
  // hold register supplies zero for an unwritten entry or the byte written in
  // the same cycle to the address being read.
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_q;
  logic              ram_hold_en;
  logic [7:0]        ram_hold;
  logic              ram_hold_en_next;
  logic [7:0]        ram_hold_next;
  logic [7:0]        ram_byte;

  assign ram_byte = ram_hold_en ? ram_hold : ram_q;

  bcdrtc_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_q.write_data),
    .raddr(ram_pointer_next[RAM_AW-1:0]),
    .rdata(ram_q)
  );

  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
  endfunction

  // Divide by ten through the reciprocal 205/2048, exact below 1029.
  function automatic logic [7:0] to_bcd(input logic [7:0] d);
    logic [15:0] q;
    logic [7:0]  r;
    q = (16'(d) * 16'd205) >> 11;
    r = d - 8'(q[7:0] * 8'd10);
    return {q[3:0], r[3:0]};
  endfunction

  function automatic logic [7:0] month_days(input logic [7:0] m, input logic [7:0] y,
                                            input logic [7:0] c);
    logic leap;
    leap = ((y[1:0] == 2'd0) && (y != 8'd0) && (y != 8'd100))
        || ((y == 8'd0) && (c[1:0] == 2'd0))
        || ((y == 8'd100) && (c[1:0] == 2'd3));
    case (m)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: return 8'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                    return 8'd30;
      default:                                    return leap ? 8'd29 : 8'd28;
    endcase
  endfunction

  always_comb begin
    logic [7:0]  s, mi, h, d, mo, y, c;
    logic [15:0] wd_sum;
    logic        te, ready, m1, m2, m3, m4, hit, wdr;
    logic [7:0]  rd;
    logic [2:0]  ti;
    logic [RAM_AW-1:0] ridx;

    user_time_next         = user_time;
    internal_time_next     = internal_time;
    month_control_next     = month_control;
    alarm_regs_next        = alarm_regs;
    watchdog_regs_next     = watchdog_regs;
    watchdog_centis_next   = watchdog_centis;
    watchdog_prescale_next = watchdog_prescale;
    control_a_next         = control_a;
    control_b_next         = control_b;
    ram_pointer_next       = ram_pointer;
    second_prescale_next   = second_prescale;
    transfer_count_next    = transfer_count;
    sync_pending_next      = sync_pending;
    sync_needed_next       = sync_needed;
    last_te_next           = last_te;
    ram_valid_next         = ram_valid;
    ram_we    = 1'b0;
    ram_waddr = ram_pointer[RAM_AW-1:0];
    rd  = '0;
    wdr = 1'b0;
    ti  = in_q.reg_address[2:0];
    s = '0; mi = '0; h = '0; d = '0; mo = '0; y = '0; c = '0;
    wd_sum = '0;
    te = 1'b0; ready = 1'b0; hit = 1'b0;
    m1 = 1'b0; m2 = 1'b0; m3 = 1'b0; m4 = 1'b0;

    if (fire) begin
      unique case (in_q.command)
        CMD_READ: begin
          unique case (in_q.reg_address) inside
            [REG_SEC:REG_CENTURY]: begin
              rd = user_time[ti];
              if (ti == TIME_DOW) begin
                rd = rd & 8'h07;
              end
              if (ti == TIME_MONTH) begin
                rd = rd | month_control;
              end
            end
            [REG_ALARM0:REG_ALARM3]: rd = alarm_regs[in_q.reg_address[1:0]];
            REG_WDOG0, REG_WDOG1:    rd = watchdog_regs[in_q.reg_address[0]];
            REG_CTRL_A: begin
              rd = control_a;
              control_a_next = control_a & 8'hF0;
            end
            REG_CTRL_B:  rd = control_b;
            REG_RAM_PTR: rd = ram_pointer;
            REG_RAM_DATA: begin
              rd = ram_byte;
              if (control_b[5]) begin
                ram_pointer_next = ram_pointer + 8'd1;
              end
            end
            default: ;
          endcase
        end

        CMD_WRITE: begin
          unique case (in_q.reg_address) inside
            [REG_SEC:REG_CENTURY]: begin
              user_time_next[ti] = in_q.write_data;
              if (ti == TIME_DOW) begin
                user_time_next[ti] = in_q.write_data & 8'h07;
              end
              if (ti == TIME_MONTH) begin
                month_control_next = in_q.write_data & 8'hE0;
                user_time_next[ti] = in_q.write_data & 8'h1F;
              end
              sync_pending_next = 1'b1;
              if (control_b[7] && transfer_count >= 32'(transfer_delay_cycles)) begin
                internal_time_next = user_time_next;
                sync_pending_next  = 1'b0;
                sync_needed_next   = 1'b0;
              end
            end
            [REG_ALARM0:REG_ALARM3]: begin
              alarm_regs_next[in_q.reg_address[1:0]] = in_q.write_data;
            end
            REG_WDOG0, REG_WDOG1: begin
              watchdog_regs_next[in_q.reg_address[0]] = in_q.write_data;
              wd_sum = 16'(from_bcd(watchdog_regs_next[1])) * 16'd100
                     + 16'(from_bcd(watchdog_regs_next[0]));
              watchdog_centis_next   = (wd_sum > 16'(WDOG_MAX)) ? WDOG_MAX : wd_sum[13:0];
              watchdog_prescale_next = '0;
            end
            REG_CTRL_A: begin
              control_a_next = (in_q.write_data & 8'hF0)
                             | ((control_a & 8'h0F) & ~(in_q.write_data & 8'h0F));
            end
            REG_CTRL_B: begin
              control_b_next = in_q.write_data;
              if (control_a[2] && control_b_next[2]) begin
                control_a_next[0] = 1'b1;
              end
              if (control_b_next[1]) begin
                wd_sum = 16'(from_bcd(watchdog_regs[1])) * 16'd100
                       + 16'(from_bcd(watchdog_regs[0]));
                watchdog_centis_next   = (wd_sum > 16'(WDOG_MAX)) ? WDOG_MAX : wd_sum[13:0];
                watchdog_prescale_next = '0;
              end
            end
            REG_RAM_PTR: ram_pointer_next = in_q.write_data;
            REG_RAM_DATA: begin
              ram_we = 1'b1;
              ram_valid_next[ram_waddr] = 1'b1;
              if (control_b[5]) begin
                ram_pointer_next = ram_pointer + 8'd1;
              end
            end
            default: ;
          endcase
        end

        CMD_TICK: begin
          // Transfer-enable hold counter.
          te = control_b[7];
          if (!te) begin
            transfer_count_next = '0;
          end else if (!last_te) begin
            transfer_count_next = 32'd1;
          end else if (transfer_count != '1) begin
            transfer_count_next = transfer_count + 32'd1;
          end
          last_te_next = te;
          ready = te && (transfer_count_next >= 32'(transfer_delay_cycles));
          if (ready && sync_pending) begin
            internal_time_next = user_time;
            sync_pending_next  = 1'b0;
            sync_needed_next   = 1'b0;
          end

          if (month_control[7]) begin
            second_prescale_next = second_prescale + 27'd1;
            if (second_prescale_next >= cycles_per_second) begin
              second_prescale_next = '0;
              // Calendar advance by one second.
              s  = from_bcd(internal_time_next[0]) + 8'd1;
              mi = from_bcd(internal_time_next[1]);
              h  = from_bcd(internal_time_next[2]);
              d  = from_bcd(internal_time_next[4]);
              mo = from_bcd(internal_time_next[5]);
              y  = from_bcd(internal_time_next[6]);
              c  = from_bcd(internal_time_next[7]);
              if (s >= 8'd60) begin
                s  = '0;
                mi = mi + 8'd1;
                if (mi >= 8'd60) begin
                  mi = '0;
                  h  = h + 8'd1;
                  if (h >= 8'd24) begin
                    h = '0;
                    internal_time_next[3] = (internal_time_next[3] == 8'd7) ? 8'd1
                                          : internal_time_next[3] + 8'd1;
                    d = d + 8'd1;
                    if (d > month_days(mo, y, c)) begin
                      d  = 8'd1;
                      mo = mo + 8'd1;
                      if (mo > 8'd12) begin
                        mo = 8'd1;
                        y  = y + 8'd1;
                        if (y > 8'd99) begin
                          y = '0;
                          c = c + 8'd1;
                          if (c > 8'd39) begin
                            c = '0;
                          end
                        end
                      end
                    end
                  end
                end
              end
              internal_time_next[0] = to_bcd(s);
              internal_time_next[1] = to_bcd(mi);
              internal_time_next[2] = to_bcd(h);
              internal_time_next[4] = to_bcd(d);
              internal_time_next[5] = to_bcd(mo);
              internal_time_next[6] = to_bcd(y);
              internal_time_next[7] = to_bcd(c);

              // Alarm compare against the new time; a set mask bit is a
              // don't-care, and all four masked disables the alarm.
              m1 = alarm_regs[0][7];
              m2 = alarm_regs[1][7];
              m3 = alarm_regs[2][7];
              m4 = alarm_regs[3][7];
              if (!(m1 && m2 && m3 && m4)) begin
                hit = (m1 || internal_time_next[0] == (alarm_regs[0] & 8'h7F))
                   && (m2 || internal_time_next[1] == (alarm_regs[1] & 8'h7F))
                   && (m3 || internal_time_next[2] == (alarm_regs[2] & 8'h7F));
                if (!m4) begin
                  hit = hit && (alarm_regs[3][6]
                        ? internal_time_next[3] == (alarm_regs[3] & 8'h3F)
                        : internal_time_next[4] == (alarm_regs[3] & 8'h3F));
                end
                if (hit) begin
                  control_a_next[3] = 1'b1;
                  if (control_b[3]) begin
                    control_a_next[0] = 1'b1;
                  end
                end
              end

              if (ready) begin
                user_time_next   = internal_time_next;
                sync_needed_next = 1'b0;
              end else begin
                sync_needed_next = 1'b1;
              end
            end else if (ready && sync_needed_next) begin
              user_time_next   = internal_time_next;
              sync_needed_next = 1'b0;
            end
          end

          // Watchdog, counted in hundredths of a second.
          if (control_b[1] && watchdog_centis != '0) begin
            watchdog_prescale_next = watchdog_prescale + 20'd1;
            if (watchdog_prescale_next >= cycles_per_centisecond) begin
              watchdog_prescale_next = '0;
              watchdog_centis_next   = watchdog_centis - 14'd1;
              if (watchdog_centis_next == '0) begin
                control_a_next[1] = 1'b1;
                if (!control_b[0]) begin
                  control_a_next[0] = 1'b1;
                end else begin
                  control_b_next[1] = 1'b0;
                  wdr = 1'b1;
                end
              end
            end
          end
        end

        CMD_COLD: begin
          user_time_next         = START_TIME;
          internal_time_next     = START_TIME;
          month_control_next     = MONTH_CTRL_RESET;
          alarm_regs_next        = '{default: '0};
          watchdog_regs_next     = '{default: '0};
          watchdog_centis_next   = '0;
          watchdog_prescale_next = '0;
          control_a_next         = 8'h04;
          control_b_next         = '0;
          ram_pointer_next       = '0;
          second_prescale_next   = '0;
          transfer_count_next    = '0;
          sync_pending_next      = 1'b0;
          sync_needed_next       = 1'b0;
          last_te_next           = 1'b0;
          ram_valid_next         = '0;
        end

        default: ;
      endcase
    end

    result_next.read_data      = rd;
    result_next.irq_flag       = control_a_next[0];
    result_next.watchdog_reset = wdr;

    ridx = ram_pointer_next[RAM_AW-1:0];
    ram_hold_en_next = !ram_valid_next[ridx] || (ram_we && ram_waddr == ridx);
    ram_hold_next    = (ram_we && ram_waddr == ridx) ? in_q.write_data : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      user_time         <= START_TIME;
      internal_time     <= START_TIME;
      month_control     <= MONTH_CTRL_RESET;
      alarm_regs        <= '{default: '0};
      watchdog_regs     <= '{default: '0};
      watchdog_centis   <= '0;
      watchdog_prescale <= '0;
      control_a         <= '0;
      control_b         <= '0;
      ram_pointer       <= '0;
      second_prescale   <= '0;
      transfer_count    <= '0;
      sync_pending      <= 1'b0;
      sync_needed       <= 1'b0;
      last_te           <= 1'b0;
      ram_valid         <= '0;
      ram_hold_en       <= 1'b1;
      ram_hold          <= '0;
      out_valid         <= 1'b0;
    end else begin
      user_time         <= user_time_next;
      internal_time     <= internal_time_next;
      month_control     <= month_control_next;
      alarm_regs        <= alarm_regs_next;
      watchdog_regs     <= watchdog_regs_next;
      watchdog_centis   <= watchdog_centis_next;
      watchdog_prescale <= watchdog_prescale_next;
      control_a         <= control_a_next;
      control_b         <= control_b_next;
      ram_pointer       <= ram_pointer_next;
      second_prescale   <= second_prescale_next;
      transfer_count    <= transfer_count_next;
      sync_pending      <= sync_pending_next;
      sync_needed       <= sync_needed_next;
      last_te           <= last_te_next;
      ram_valid         <= ram_valid_next;
      ram_hold_en       <= ram_hold_en_next;
      ram_hold          <= ram_hold_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (fire) begin
      out_data <= result_next;
    end
  end

  // A held result always reports the IRQF level of the current state, since
  // the state only moves when a new result is loaded.
  a_irq_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.irq_flag == control_a[0])
    else $error("held IRQF result differs from control A");

  // A watchdog-reset pulse always leaves the watchdog disabled.
  a_wdr_disables_wde: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.watchdog_reset |-> !control_b[1])
    else $error("watchdog reset left WDE set");

  // The input side only stalls when a transaction is waiting in the input
  // register behind a stalled result.
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_q_valid && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

endmodule
